@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros included by request_replay_cache_unit
// Concurrent checks sampled on the rising clock, muted while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define RRC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define RRC_NEVER(lbl, clk_s, rstn_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`endif

@@ src/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types, status codes and default sizes for the request replay cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

	// Default table depth and largest reply length that may be cached
	localparam int unsigned RRC_ENTRIES   = 8;
	localparam int unsigned RRC_REPLY_MAX = 512;

	// Result status codes
	localparam logic [2:0] ST_MISS     = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_CONFLICT = 3'd2;
	localparam logic [2:0] ST_STORED   = 3'd3;
	localparam logic [2:0] ST_REFUSED  = 3'd4;

	// Request operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	// One request transfer
	typedef struct packed {
		logic        operation;
		logic        is_legacy;
		logic [31:0] proto_version;
		logic [31:0] sequence_number;
		logic [4:0]  command_code;
		logic [31:0] frame_hash;
		logic [15:0] reply_length;
	} req_t;

	// One result transfer
	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot_index;
		logic [15:0] stored_reply_length;
	} rsp_t;

	// One cached entry as held in the table memory
	typedef struct packed {
		logic [31:0] version;
		logic [31:0] seq_num;
		logic [4:0]  command;
		logic [31:0] hash;
		logic [15:0] reply_length;
	} entry_t;

endpackage

`default_nettype wire

@@ src/rrc_table.sv @@
// ----------------------------------------------------------------------------
// rrc_table
// Entry memory with one write port and one registered read port, plus one
// valid flop per entry that reset clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrc_table #(
	parameter int unsigned ENTRIES = rrc_pkg::RRC_ENTRIES,
	parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire rrc_pkg::entry_t wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output rrc_pkg::entry_t      rd_data,
	output logic                 rd_valid
);

	rrc_pkg::entry_t     mem_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	rrc_pkg::entry_t     rd_data_q;
	logic                rd_valid_q;

	// Entry payload storage, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Valid marks and the registered valid of the entry being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

`default_nettype wire

@@ src/request_replay_cache_unit.sv @@
// ----------------------------------------------------------------------------
// request_replay_cache_unit
// Replay cache for answered requests: lookups walk the table one entry per
// cycle through a single key/payload comparator; stores fill slots round-robin.
// ----------------------------------------------------------------------------
//  channel   | signals            | handshake
//  ----------+--------------------+-----------------------------------------
//  request   | start, busy, req   | transfer when start high and busy low
//  result    | done, rsp          | one-cycle strobe, no back-pressure
//
// Store, legacy lookup: result strobes the cycle after the transfer; busy
// stays low, so a new request can follow at once.
// Lookup: one table read per cycle into one comparator; the walk ends at the first
// key hit or after the last slot is compared; busy is high meanwhile.
// Reset clears all valid marks and the write pointer immediately.
// The receiver cannot stall; each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module request_replay_cache_unit #(
	parameter int unsigned CACHE_ENTRIES = rrc_pkg::RRC_ENTRIES,
	parameter int unsigned REPLY_MAX     = rrc_pkg::RRC_REPLY_MAX
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rrc_pkg::req_t req,
	output logic               done,
	output rrc_pkg::rsp_t      rsp
);

	localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);
	localparam int unsigned EXT_W = (IDX_W > 3) ? IDX_W : 3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [15:0] LEN_MAX = 16'(REPLY_MAX);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	rrc_pkg::req_t     req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  wp_q;
	logic              cmp_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              done_q;
	rrc_pkg::rsp_t     rsp_q;

	logic              accept;
	logic              wr_en;
	rrc_pkg::entry_t   wr_data;
	rrc_pkg::entry_t   rd_data;
	logic              rd_valid;
	logic              key_hit;
	logic              body_hit;
	logic              store_ok;
	logic [EXT_W-1:0]  wp_ext;
	logic [EXT_W-1:0]  cmp_ext;
	logic              fast_req;
	logic              len_ok;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_SCAN);

	// Store is taken only for a modern request within the length limit
	assign store_ok = !req.is_legacy && (req.reply_length <= LEN_MAX);
	assign wr_en    = accept && (req.operation == rrc_pkg::OP_STORE) && store_ok;

	assign wr_data.version      = req.proto_version;
	assign wr_data.seq_num      = req.sequence_number;
	assign wr_data.command      = req.command_code;
	assign wr_data.hash         = req.frame_hash;
	assign wr_data.reply_length = req.reply_length;

	rrc_table #(
		.ENTRIES (CACHE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wp_q),
		.wr_data  (wr_data),
		.rd_addr  (idx_q),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	// Shared comparator: key match, then command and fingerprint match
	assign key_hit  = rd_valid && (rd_data.version == req_q.proto_version)
		&& (rd_data.seq_num == req_q.sequence_number);
	assign body_hit = (rd_data.command == req_q.command_code)
		&& (rd_data.hash == req_q.frame_hash);

	// Slot numbers leave as their low three bits
	assign wp_ext  = EXT_W'(wp_q);
	assign cmp_ext = EXT_W'(cmp_idx_s1);

	// Request latch payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// Sequencer, write pointer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			wp_q       <= '0;
			cmp_s1     <= 1'b0;
			cmp_idx_s1 <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.operation == rrc_pkg::OP_STORE) begin
							done_q                    <= 1'b1;
							rsp_q.stored_reply_length <= '0;
							if (store_ok) begin
								rsp_q.status     <= rrc_pkg::ST_STORED;
								rsp_q.slot_index <= wp_ext[2:0];
								wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
							end else begin
								rsp_q.status     <= rrc_pkg::ST_REFUSED;
								rsp_q.slot_index <= '0;
							end
						end else if (req.is_legacy) begin
							done_q <= 1'b1;
							rsp_q  <= '{status: rrc_pkg::ST_MISS, slot_index: '0,
								stored_reply_length: '0};
						end else begin
							state_q <= S_SCAN;
							idx_q   <= '0;
							cmp_s1  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					// Issue the next read while comparing the previous one
					cmp_s1     <= 1'b1;
					cmp_idx_s1 <= idx_q;
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + 1'b1;
					end
					if (cmp_s1 && key_hit) begin
						state_q          <= S_IDLE;
						done_q           <= 1'b1;
						rsp_q.slot_index <= cmp_ext[2:0];
						if (body_hit) begin
							rsp_q.status              <= rrc_pkg::ST_DUP;
							rsp_q.stored_reply_length <= rd_data.reply_length;
						end else begin
							rsp_q.status              <= rrc_pkg::ST_CONFLICT;
							rsp_q.stored_reply_length <= '0;
						end
					end else if (cmp_s1 && (cmp_idx_s1 == LAST_IDX)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						rsp_q   <= '{status: rrc_pkg::ST_MISS, slot_index: '0,
							stored_reply_length: '0};
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	assign fast_req = start && !busy && (req.operation || req.is_legacy);
	assign len_ok   = !done || (rsp.status == rrc_pkg::ST_DUP)
		|| (rsp.stored_reply_length == 16'd0);

	`RRC_ASSERT(a_fast_answer, clk, arst_n, fast_req |=> (done && !busy), "fast request late")
	`RRC_NEVER(a_done_idle, clk, arst_n, done && busy, "result strobed during table walk")
	`RRC_ASSERT(a_len_dup_only, clk, arst_n, len_ok, "reply length on non-duplicate")
	`RRC_ASSERT(a_wp_range, clk, arst_n, wp_q <= LAST_IDX, "write pointer beyond table")

endmodule

`default_nettype wire
